// ===== hw/rtl/tlbpt_pkg.sv =====
// Shared constants and types of the TLB and page table translator.
package tlbpt_pkg;

	localparam int TLB_DEPTH      = 16;
	localparam int NUM_PAGES      = 256;
	localparam int BYTES_PER_PAGE = 256;
	localparam int FRAME_COUNT    = 256;

	localparam int ADDR_W   = 16;
	localparam int OFFSET_W = $clog2(BYTES_PER_PAGE);
	localparam int PAGE_W   = $clog2(NUM_PAGES);
	localparam int FRAME_W  = $clog2(FRAME_COUNT);
	localparam int TLB_IDX_W = $clog2(TLB_DEPTH);
	localparam int CNT_W    = 32;

	// result word: address, hit, fault, three counters, padded to bytes
	localparam int OUT_FIELDS_W = ADDR_W + 2 + 3 * CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;

	// registered TLB search result
	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_lookup_t;

	// TLB refill request, issued once per miss
	typedef struct packed {
		logic   en;
		page_t  page;
		frame_t frame;
	} tlb_refill_t;

	// page table read result and allocation state
	typedef struct packed {
		logic   valid;
		frame_t frame;
		frame_t free_frame;
	} pt_status_t;

endpackage

// ===== hw/rtl/tlbpt_tlb.sv =====
// Fully associative TLB with lowest-index match and FIFO refill.
module tlbpt_tlb (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                lookup_en,
	input  tlbpt_pkg::page_t    lookup_page,
	output tlbpt_pkg::tlb_lookup_t lookup_s1,
	input  tlbpt_pkg::tlb_refill_t refill
);
	import tlbpt_pkg::*;

	page_t                tag_q   [TLB_DEPTH];
	frame_t               frame_q [TLB_DEPTH];
	logic [TLB_DEPTH-1:0] valid_q;
	logic [TLB_IDX_W-1:0] fill_ptr_q;
	tlb_lookup_t          match;

	// parallel compare, lowest index wins
	always_comb begin
		match = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == lookup_page) begin
				match.hit   = 1'b1;
				match.frame = frame_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_en) begin
			lookup_s1 <= match;
		end
	end

	// entry payload, no reset needed
	always_ff @(posedge clk) begin
		if (refill.en) begin
			tag_q[fill_ptr_q]   <= refill.page;
			frame_q[fill_ptr_q] <= refill.frame;
		end
	end

	// valid bits and fill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fill_ptr_q <= '0;
		end else if (refill.en) begin
			valid_q[fill_ptr_q] <= 1'b1;
			if (fill_ptr_q == TLB_IDX_W'(TLB_DEPTH - 1)) begin
				fill_ptr_q <= '0;
			end else begin
				fill_ptr_q <= fill_ptr_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tlbpt_page_table.sv =====
// Page table memory with valid bits and the wrapping free-frame counter.
module tlbpt_page_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  tlbpt_pkg::page_t     rd_page,
	input  logic                 alloc_en,
	input  tlbpt_pkg::page_t     alloc_page,
	output tlbpt_pkg::pt_status_t status
);
	import tlbpt_pkg::*;

	frame_t                mem [NUM_PAGES];
	logic [NUM_PAGES-1:0]  valid_q;
	frame_t                rd_frame_s1;
	logic                  rd_valid_s1;
	frame_t                free_frame_q;

	// synchronous read, and the allocation write of the free frame
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_frame_s1 <= mem[rd_page];
		end
		if (alloc_en) begin
			mem[alloc_page] <= free_frame_q;
		end
	end

	// valid bits and free-frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rd_valid_s1  <= 1'b0;
			free_frame_q <= '0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_page];
			end
			if (alloc_en) begin
				valid_q[alloc_page] <= 1'b1;
				if (free_frame_q == FRAME_W'(FRAME_COUNT - 1)) begin
					free_frame_q <= '0;
				end else begin
					free_frame_q <= free_frame_q + 1'b1;
				end
			end
		end
	end

	assign status.valid      = rd_valid_s1;
	assign status.frame      = rd_frame_s1;
	assign status.free_frame = free_frame_q;

endmodule

// ===== hw/rtl/tlb_page_table_translator_core.sv =====
// The TLB search and page table read are registered at the address transfer, and the
// result in the output register. The input takes no new address while one is held; the
// page table memory read feeds the decision, write-back and TLB refill of the held item.
// Output stalls keep the item held until the result is taken.
// Reset clears TLB and page table valid bits, fill pointer, free frame and
// counters at once; no clearing pass follows.
module tlb_page_table_translator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] virtual_address
	input  logic [tlbpt_pkg::ADDR_W-1:0]      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [15:0] physical_address, [16] tlb_hit, [17] page_fault,
	// [49:18] translated_count, [81:50] fault_count, [113:82] hit_count, rest zero
	output logic [tlbpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tlbpt_pkg::*;

	logic                s_fire;
	logic                fire_s1;
	logic                s1_valid_q;
	logic [OFFSET_W-1:0] offset_s1;
	page_t               page_s1;
	page_t               in_page;
	tlb_lookup_t         lookup_s1;
	tlb_refill_t         refill;
	pt_status_t          pt_status;
	logic                fault;
	frame_t              frame;
	logic                m_valid_q;
	logic [ADDR_W-1:0]   phys_q;
	logic                hit_q;
	logic                fault_q;
	logic [CNT_W-1:0]    trans_q;
	logic [CNT_W-1:0]    faults_q;
	logic [CNT_W-1:0]    hits_q;

	assign in_page       = PAGE_W'(s_axis_tdata >> OFFSET_W);
	assign s_axis_tready = !s1_valid_q;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign fire_s1       = s1_valid_q && (!m_valid_q || m_axis_tready);

	tlbpt_tlb u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_en   (s_fire),
		.lookup_page (in_page),
		.lookup_s1   (lookup_s1),
		.refill      (refill)
	);

	tlbpt_page_table u_pt (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (s_fire),
		.rd_page    (in_page),
		.alloc_en   (fire_s1 && fault),
		.alloc_page (page_s1),
		.status     (pt_status)
	);

	// frame select: TLB, then page table, else a fresh frame
	always_comb begin
		fault = 1'b0;
		priority if (lookup_s1.hit) begin
			frame = lookup_s1.frame;
		end else if (pt_status.valid) begin
			frame = pt_status.frame;
		end else begin
			frame = pt_status.free_frame;
			fault = 1'b1;
		end
	end

	assign refill.en    = fire_s1 && !lookup_s1.hit;
	assign refill.page  = page_s1;
	assign refill.frame = frame;

	// address hold for the held item, and the result registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			offset_s1 <= s_axis_tdata[OFFSET_W-1:0];
			page_s1   <= in_page;
		end
		if (fire_s1) begin
			phys_q  <= ADDR_W'({frame, offset_s1});
			hit_q   <= lookup_s1.hit;
			fault_q <= fault;
		end
	end

	// stage valid, output valid and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			trans_q    <= '0;
			faults_q   <= '0;
			hits_q     <= '0;
		end else begin
			if (s_fire) begin
				s1_valid_q <= 1'b1;
			end else if (fire_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (fire_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (fire_s1) begin
				if (trans_q != '1) begin
					trans_q <= trans_q + 1'b1;
				end
				if (fault && faults_q != '1) begin
					faults_q <= faults_q + 1'b1;
				end
				if (lookup_s1.hit && hits_q != '1) begin
					hits_q <= hits_q + 1'b1;
				end
			end
		end
	end

	// counters change only on a new result, so they feed the output directly
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({hits_q, faults_q, trans_q, fault_q, hit_q, phys_q});

endmodule

// ===== hw/rtl/tlbpt_checker.sv =====
// Port-level checks of the translator, bound to the top level.
module tlbpt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [tlbpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tlbpt_pkg::*;

	// a TLB hit never faults
	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[17]))
		else $error("hit and fault both set");

	// one item in the input stage: no transfer right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// hit and fault counts never exceed the translation count
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[113:82] <= m_axis_tdata[49:18]) &&
			(m_axis_tdata[81:50] <= m_axis_tdata[49:18]))
		else $error("counter exceeds translation count");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind tlb_page_table_translator_core tlbpt_checker u_tlbpt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_tlb_page_table_translator_core.sv =====
// Self-checking testbench for the TLB and page table address translator core.
module tb_tlb_page_table_translator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tlbpt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOT_PAGES      = 48;
	localparam int PAD_W          = OUT_TDATA_W - OUT_FIELDS_W;

	// one translation result as it should leave the block
	typedef struct {
		logic [ADDR_W-1:0] phys_addr;
		logic              tlb_hit;
		logic              page_fault;
		logic [CNT_W-1:0]  translated;
		logic [CNT_W-1:0]  faulted;
		logic [CNT_W-1:0]  hit_total;
	} translation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ADDR_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// translator state mirrored by the predictor
	page_t  tlb_page_m [TLB_DEPTH];
	frame_t tlb_frame_m [TLB_DEPTH];
	logic   tlb_valid_m [TLB_DEPTH];
	frame_t pt_frame_m [NUM_PAGES];
	logic   pt_valid_m [NUM_PAGES];
	logic [TLB_IDX_W-1:0] fill_ptr_m;
	frame_t free_frame_m;
	logic [CNT_W-1:0] translations_m, faults_m, hits_m;

	translation_t expected_translations[$];
	int mismatch_count = 0;
	int result_index = 0;
	int quiet_cycles = 0;

	// traffic shaping knobs
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic hold_active = 1'b0;
	event hold_start;

	// recently used pages, to steer random traffic toward TLB hits
	page_t recent_pages [TLB_DEPTH];
	int recent_wr = 0;

	tlb_page_table_translator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [CNT_W-1:0] sat_increment(logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// predicted translation of one address; updates the mirrored state
	function automatic translation_t translate_address(logic [ADDR_W-1:0] va);
		translation_t r;
		page_t  pg;
		frame_t fr;
		logic   hit;
		logic   fault;
		pg = va[OFFSET_W +: PAGE_W];
		fr = '0;
		hit = 1'b0;
		fault = 1'b0;
		// lowest matching entry wins
		for (int i = 0; i < TLB_DEPTH; i++) begin
			if (!hit && tlb_valid_m[i] && tlb_page_m[i] == pg) begin
				hit = 1'b1;
				fr = tlb_frame_m[i];
			end
		end
		if (!hit) begin
			if (pt_valid_m[pg]) begin
				fr = pt_frame_m[pg];
			end else begin
				// demand paging: next free frame, counter wraps
				fault = 1'b1;
				fr = free_frame_m;
				pt_frame_m[pg] = fr;
				pt_valid_m[pg] = 1'b1;
				free_frame_m = free_frame_m + 1'b1;
			end
			// FIFO refill of the TLB
			tlb_page_m[fill_ptr_m] = pg;
			tlb_frame_m[fill_ptr_m] = fr;
			tlb_valid_m[fill_ptr_m] = 1'b1;
			fill_ptr_m = fill_ptr_m + 1'b1;
		end
		translations_m = sat_increment(translations_m);
		if (fault)
			faults_m = sat_increment(faults_m);
		if (hit)
			hits_m = sat_increment(hits_m);
		r.phys_addr = {fr, va[OFFSET_W-1:0]};
		r.tlb_hit = hit;
		r.page_fault = fault;
		r.translated = translations_m;
		r.faulted = faults_m;
		r.hit_total = hits_m;
		return r;
	endfunction

	// random address: recent pages most often, a hot set, the rest anywhere
	function automatic logic [ADDR_W-1:0] pick_address();
		page_t pg;
		int r;
		r = $urandom_range(99);
		if (r < 45)
			pg = recent_pages[$urandom_range(TLB_DEPTH-1)];
		else if (r < 70)
			pg = page_t'($urandom_range(HOT_PAGES-1));
		else
			pg = page_t'($urandom_range(NUM_PAGES-1));
		recent_pages[recent_wr] = pg;
		recent_wr = (recent_wr + 1) % TLB_DEPTH;
		return {pg, OFFSET_W'($urandom_range(BYTES_PER_PAGE-1))};
	endfunction

	// offer one address and wait for its transfer
	task automatic send_address(input logic [ADDR_W-1:0] va);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= va;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic stop_offering();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct <= stall_pct;
	endtask

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk)
		m_axis_tready <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);

	initial begin
		forever begin
			@(hold_start);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// predict on input transfers, check on output transfers
	always @(posedge clk) begin
		translation_t want;
		logic [PAD_W-1:0] pad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pad = m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];
			if (expected_translations.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d: unexpected transfer, tdata=%h",
						result_index, m_axis_tdata);
			end else begin
				want = expected_translations.pop_front();
				if (m_axis_tdata[15:0] !== want.phys_addr
						|| m_axis_tdata[16] !== want.tlb_hit
						|| m_axis_tdata[17] !== want.page_fault
						|| m_axis_tdata[49:18] !== want.translated
						|| m_axis_tdata[81:50] !== want.faulted
						|| m_axis_tdata[113:82] !== want.hit_total
						|| pad !== '0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$write("result %0d: expected pa=%h hit=%b fault=%b n=%0d/%0d/%0d,",
							result_index, want.phys_addr, want.tlb_hit, want.page_fault,
							want.translated, want.faulted, want.hit_total);
						$display(" got pa=%h hit=%b fault=%b n=%0d/%0d/%0d pad=%h",
							m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17],
							m_axis_tdata[49:18], m_axis_tdata[81:50],
							m_axis_tdata[113:82], pad);
					end
				end
			end
			result_index++;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_translations.push_back(translate_address(s_axis_tdata));
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// address extremes: all zeros, all ones, offset and page extremes
	task automatic test_boundary_addresses();
		set_idling(0, 0);
		send_address(16'h0000);
		send_address(16'hFFFF);
		send_address(16'h00FF);
		send_address(16'hFF00);
		stop_offering();
	endtask

	// miss with fault, then a TLB hit on the same page
	task automatic test_tlb_hit_after_refill();
		send_address(16'h1234);
		send_address(16'h12AB);
		stop_offering();
	endtask

	// sixteen fresh pages push out the oldest entries; revisits hit the page table
	task automatic test_tlb_eviction();
		for (int i = 0; i < TLB_DEPTH; i++)
			send_address({8'h20 + 8'(i), 8'(i * 17)});
		send_address(16'h1256);
		send_address(16'h0042);
		stop_offering();
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		set_idling(idle_pct, stall_pct);
		for (int i = 0; i < count; i++)
			send_address(pick_address());
		stop_offering();
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure_fill();
		set_idling(0, 0);
		->hold_start;
		for (int i = 0; i < 40; i++)
			send_address(pick_address());
		stop_offering();
	endtask

	// touch every page once in shuffled order; the free frame counter wraps
	task automatic test_frame_exhaustion();
		page_t order [NUM_PAGES];
		page_t tmp;
		int j;
		for (int i = 0; i < NUM_PAGES; i++)
			order[i] = page_t'(i);
		for (int i = NUM_PAGES - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		set_idling(12, 12);
		for (int i = 0; i < NUM_PAGES; i++)
			send_address({order[i], OFFSET_W'($urandom_range(BYTES_PER_PAGE-1))});
		stop_offering();
	endtask

	initial begin
		// mirrored state after reset
		for (int i = 0; i < TLB_DEPTH; i++) begin
			tlb_page_m[i] = '0;
			tlb_frame_m[i] = '0;
			tlb_valid_m[i] = 1'b0;
			recent_pages[i] = '0;
		end
		for (int i = 0; i < NUM_PAGES; i++) begin
			pt_frame_m[i] = '0;
			pt_valid_m[i] = 1'b0;
		end
		fill_ptr_m = '0;
		free_frame_m = '0;
		translations_m = '0;
		faults_m = '0;
		hits_m = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_boundary_addresses();
		test_tlb_hit_after_refill();
		test_tlb_eviction();
		test_random_traffic(120, 0, 0);
		test_random_traffic(120, 75, 0);
		test_random_traffic(120, 0, 75);
		test_random_traffic(120, 12, 12);
		test_backpressure_fill();
		test_frame_exhaustion();
		test_random_traffic(80, 12, 12);

		// drain outstanding results
		set_idling(0, 0);
		while (expected_translations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_translations.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_tlb.sv
hw/rtl/tlbpt_page_table.sv
hw/rtl/tlb_page_table_translator_core.sv
hw/rtl/tlbpt_checker.sv
test/tb_tlb_page_table_translator_core.sv
